// ===== hdl/gbs_pkg.sv =====
// ---------------------------------------------------------------------------
// gbs_pkg
// Shared constants for the greedy box suppression core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gbs_pkg;

  localparam int unsigned SCORE_W   = 16;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned IOU_SHIFT = 16;
  localparam logic [LIMIT_W-1:0] IOU_RESET = 16'd29491;

endpackage
`default_nettype wire

// ===== hdl/greedy_box_suppression_core.sv =====
// ---------------------------------------------------------------------------
// greedy_box_suppression_core
// Greedy IoU non-maximum suppression over one set of candidate boxes.
// ---------------------------------------------------------------------------
// Push candidate boxes until one marked last_box; the core then ranks them
// by descending score (equal scores in arrival order), keeps every box not
// yet suppressed and suppresses each later box whose overlap with a kept box
// exceeds iou_limit, i.e. intersection * 65536 > iou_limit * union. Kept
// boxes come out in score order, last_kept on the final beat and
// set_overflowed on every beat of a set that lost boxes beyond MAX_BOXES.
// Boxes enter the store through a four-deep queue while the engine is idle.
// Once the set closes, the engine runs one pick per kept box: a scan of
// every entry for the best live box (read, compare), then a suppression
// pass over each live entry through the box store and the IoU datapath
// (read, extents, products, union, compare); no boxes are loaded meanwhile.
// Write iou_limit only while the core is idle; cfg_ready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module greedy_box_suppression_core #(
  parameter int unsigned MAX_BOXES   = 64,
  parameter int unsigned COORD_WIDTH = 18
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [gbs_pkg::LIMIT_W-1:0]  cfg_data,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [COORD_WIDTH-1:0] box_left,
  input  wire logic signed [COORD_WIDTH-1:0] box_top,
  input  wire logic signed [COORD_WIDTH-1:0] box_right,
  input  wire logic signed [COORD_WIDTH-1:0] box_bottom,
  input  wire logic [gbs_pkg::SCORE_W-1:0]  box_score,
  input  wire logic                         last_box,
  output logic                              empty,
  input  wire logic                         pop,
  output logic signed [COORD_WIDTH-1:0]     kept_left,
  output logic signed [COORD_WIDTH-1:0]     kept_top,
  output logic signed [COORD_WIDTH-1:0]     kept_right,
  output logic signed [COORD_WIDTH-1:0]     kept_bottom,
  output logic [gbs_pkg::SCORE_W-1:0]       kept_score,
  output logic                              last_kept,
  output logic                              set_overflowed
);
  import gbs_pkg::*;

  localparam int unsigned BW = 4 * COORD_WIDTH + SCORE_W + 1;
  localparam int unsigned CW = $clog2(MAX_BOXES+1);

  logic [LIMIT_W-1:0] iou_limit;
  logic [BW-1:0]      q_data;
  logic               q_empty;
  logic               eng_pop;
  logic               out_valid;
  logic [CW-1:0]      loaded;

  // Threshold register: take every write beat.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_limit <= IOU_RESET;
    end else if (cfg_valid) begin
      iou_limit <= cfg_data;
    end
  end

  // Front: queue the candidates ahead of the engine; full holds intake off while the engine is busy.
  gbs_fifo #(
    .WIDTH (BW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data ({box_left, box_top, box_right, box_bottom, box_score, last_box}),
    .full    (full),
    .pop     (eng_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Back: store, rank, suppress and emit.
  gbs_engine #(
    .MAX_BOXES   (MAX_BOXES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .iou_limit  (iou_limit),
    .in_valid   (!q_empty),
    .in_data    (q_data),
    .in_pop     (eng_pop),
    .out_valid  (out_valid),
    .out_pop    (pop),
    .out_left   (kept_left),
    .out_top    (kept_top),
    .out_right  (kept_right),
    .out_bottom (kept_bottom),
    .out_score  (kept_score),
    .out_last   (last_kept),
    .out_ovf    (set_overflowed),
    .loaded     (loaded)
  );

  assign empty = !out_valid;

`ifndef SYNTHESIS
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    eng_pop |-> !q_empty) else $error("engine drew from an empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= CW'(MAX_BOXES)) else $error("box store filled past capacity");

  a_no_beat_loss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid) else $error("result beat dropped");
`endif

endmodule
`default_nettype wire

// ===== hdl/gbs_fifo.sv =====
// ---------------------------------------------------------------------------
// gbs_fifo
// Four-entry candidate queue between the intake and the suppression engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gbs_fifo #(
  parameter int unsigned WIDTH = 89
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  import gbs_pkg::*;

  logic [WIDTH-1:0] slots [4];
  logic [1:0]       wr_ptr;
  logic [1:0]       rd_ptr;
  logic [2:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == 3'd4);
  assign empty   = (fill == 3'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 3'd1;
        2'b01:   fill <= fill - 3'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gbs_engine.sv =====
// ---------------------------------------------------------------------------
// gbs_engine
// Stores a set of boxes, then repeatedly picks the best live box and
// suppresses the overlapping rest, emitting kept boxes in score order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gbs_engine #(
  parameter int unsigned MAX_BOXES   = 64,
  parameter int unsigned COORD_WIDTH = 18
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [gbs_pkg::LIMIT_W-1:0]   iou_limit,
  input  wire logic                          in_valid,
  input  wire logic [4*COORD_WIDTH+gbs_pkg::SCORE_W:0] in_data,
  output logic                               in_pop,
  output logic                               out_valid,
  input  wire logic                          out_pop,
  output logic signed [COORD_WIDTH-1:0]      out_left,
  output logic signed [COORD_WIDTH-1:0]      out_top,
  output logic signed [COORD_WIDTH-1:0]      out_right,
  output logic signed [COORD_WIDTH-1:0]      out_bottom,
  output logic [gbs_pkg::SCORE_W-1:0]        out_score,
  output logic                               out_last,
  output logic                               out_ovf,
  output logic [$clog2(MAX_BOXES+1)-1:0]     loaded
);
  import gbs_pkg::*;

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned IW  = $clog2(MAX_BOXES);
  localparam int unsigned CW  = $clog2(MAX_BOXES+1);
  localparam int unsigned EW  = W + 1;
  localparam int unsigned AW  = 2 * EW;
  localparam int unsigned UW  = AW + 1;
  localparam int unsigned RW  = UW + LIMIT_W;

  typedef struct packed {
    logic signed [W-1:0] l;
    logic signed [W-1:0] t;
    logic signed [W-1:0] r;
    logic signed [W-1:0] b;
    logic [SCORE_W-1:0]  s;
  } box_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_FRD   = 10'b0000000010,
    ST_FCMP  = 10'b0000000100,
    ST_HAND  = 10'b0000001000,
    ST_SRD   = 10'b0000010000,
    ST_SEXT  = 10'b0000100000,
    ST_SMUL  = 10'b0001000000,
    ST_SUN   = 10'b0010000000,
    ST_SCMP  = 10'b0100000000,
    ST_FLUSH = 10'b1000000000
  } state_t;

  function automatic logic [EW-1:0] extent(logic signed [W-1:0] lo,
                                           logic signed [W-1:0] hi);
    logic signed [EW-1:0] d;
    d = EW'(hi) - EW'(lo);
    return (hi > lo) ? d : '0;
  endfunction

  state_t          state;
  box_t            store [MAX_BOXES];
  box_t            rd;
  box_t            in_box;
  logic            in_last;
  logic [CW-1:0]   count;
  logic            ovf;
  logic [MAX_BOXES-1:0] retired;
  logic [IW-1:0]   idx;
  logic [CW-1:0]   idx_inc;
  logic            at_end;
  logic            best_valid;
  logic [IW-1:0]   best_idx;
  box_t            best;
  logic            pend_valid;
  box_t            pend;
  logic            out_free;
  logic            take;
  logic [EW-1:0]   iw, ih, w1, h1, w2, h2;
  logic [AW-1:0]   inter, a1, a2;
  logic [UW-1:0]   uni;
  logic [RW-1:0]   lhs;
  logic [RW-1:0]   rhs;
  logic signed [W-1:0] x_lo, x_hi, y_lo, y_hi;

  assign in_box  = in_data[4*W+SCORE_W:1];
  assign in_last = in_data[0];
  assign idx_inc = CW'(idx) + CW'(1);
  assign at_end  = (idx_inc == count);
  assign out_free = !out_valid || out_pop;
  assign in_pop  = (state == ST_IDLE) && in_valid;
  assign loaded  = count;
  assign take    = !retired[idx] && (!best_valid || (rd.s > best.s));
  assign x_lo    = (pend.l > rd.l) ? pend.l : rd.l;
  assign x_hi    = (pend.r < rd.r) ? pend.r : rd.r;
  assign y_lo    = (pend.t > rd.t) ? pend.t : rd.t;
  assign y_hi    = (pend.b < rd.b) ? pend.b : rd.b;
  assign rhs     = RW'(uni) * RW'(iou_limit);

  // Store: written at the fill position, read at the scan index.
  always_ff @(posedge clk) begin
    if (in_pop && (count < CW'(MAX_BOXES))) begin
      store[count[IW-1:0]] <= in_box;
    end
    rd <= store[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      ovf        <= 1'b0;
      retired    <= '0;
      idx        <= '0;
      best_valid <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (count < CW'(MAX_BOXES)) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (in_last) begin
              idx        <= '0;
              best_valid <= 1'b0;
              state      <= ST_FRD;
            end
          end
        end
        ST_FRD: state <= ST_FCMP;
        ST_FCMP: begin
          if (take) begin
            best_valid <= 1'b1;
            best_idx   <= idx;
            best       <= rd;
          end
          if (at_end) begin
            idx   <= '0;
            state <= (best_valid || take) ? ST_HAND : ST_FLUSH;
          end else begin
            idx   <= idx + IW'(1);
            state <= ST_FRD;
          end
        end
        ST_HAND: begin
          // Release the previous keeper as a non-final beat.
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid  <= 1'b1;
              out_left   <= pend.l;
              out_top    <= pend.t;
              out_right  <= pend.r;
              out_bottom <= pend.b;
              out_score  <= pend.s;
              out_last   <= 1'b0;
              out_ovf    <= ovf;
            end
            pend_valid        <= 1'b1;
            pend              <= best;
            retired[best_idx] <= 1'b1;
            best_valid        <= 1'b0;
            idx               <= '0;
            state             <= ST_SRD;
          end
        end
        ST_SRD: begin
          if (retired[idx]) begin
            if (at_end) begin
              idx   <= '0;
              state <= ST_FRD;
            end else begin
              idx <= idx + IW'(1);
            end
          end else begin
            state <= ST_SEXT;
          end
        end
        ST_SEXT: begin
          iw    <= extent(x_lo, x_hi);
          ih    <= extent(y_lo, y_hi);
          w1    <= extent(pend.l, pend.r);
          h1    <= extent(pend.t, pend.b);
          w2    <= extent(rd.l, rd.r);
          h2    <= extent(rd.t, rd.b);
          state <= ST_SMUL;
        end
        ST_SMUL: begin
          inter <= AW'(iw) * AW'(ih);
          a1    <= AW'(w1) * AW'(h1);
          a2    <= AW'(w2) * AW'(h2);
          state <= ST_SUN;
        end
        ST_SUN: begin
          uni   <= UW'(a1) + UW'(a2) - UW'(inter);
          lhs   <= RW'(inter) << IOU_SHIFT;
          state <= ST_SCMP;
        end
        ST_SCMP: begin
          if (lhs > rhs) begin
            retired[idx] <= 1'b1;
          end
          if (at_end) begin
            idx   <= '0;
            state <= ST_FRD;
          end else begin
            idx   <= idx + IW'(1);
            state <= ST_SRD;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_left   <= pend.l;
            out_top    <= pend.t;
            out_right  <= pend.r;
            out_bottom <= pend.b;
            out_score  <= pend.s;
            out_last   <= 1'b1;
            out_ovf    <= ovf;
            pend_valid <= 1'b0;
            retired    <= '0;
            count      <= '0;
            ovf        <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
